// File: rtl/ckvf_pkg.sv
// Package for the coalescing key/value FIFO: command and status codes,
// field widths and the control struct broadcast to the storage cells.
// No dependencies.
`timescale 1ns / 1ps

package ckvf_pkg;

    localparam int KEY_W   = 16;
    localparam int VALUE_W = 16;
    localparam int OCC_W   = 5;
    localparam int STAT_W  = 3;

    // Result tdata: out_key, out_value, occupancy, is_empty, is_full, padding
    localparam int M_DATA_W = 40;
    localparam int S_DATA_W = KEY_W + VALUE_W;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_UPDATED  = 3'd0,
        ST_APPENDED = 3'd1,
        ST_DROPPED  = 3'd2,
        ST_POPPED   = 3'd3,
        ST_EMPTY    = 3'd4
    } status_t;

    // Broadcast to every cell in the cycle a transaction is accepted
    typedef struct packed {
        logic               push;
        logic               pop;
        logic               any_hit;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } ckvf_ctrl_t;

endpackage

// File: rtl/ckvf_cell.sv
// One storage cell of the coalescing key/value FIFO chain.
// Holds one key/value pair, compares its key, takes its neighbour's pair on pop.
// Depends on ckvf_pkg.
`timescale 1ns / 1ps

module ckvf_cell
    import ckvf_pkg::*;
(
    input  logic               aclk,
    input  ckvf_ctrl_t         ctrl,
    input  logic               occupied,
    input  logic               is_tail,
    input  logic [KEY_W-1:0]   nb_key,
    input  logic [VALUE_W-1:0] nb_value,
    output logic [KEY_W-1:0]   key,
    output logic [VALUE_W-1:0] value,
    output logic               hit
);

    logic [KEY_W-1:0]   key_reg;
    logic [KEY_W-1:0]   key_next;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;

    assign hit = occupied && (key_reg == ctrl.key);

    always_comb begin
        key_next   = key_reg;
        value_next = value_reg;
        if (ctrl.pop) begin
            // advance one place toward the head
            key_next   = nb_key;
            value_next = nb_value;
        end else if (ctrl.push && hit) begin
            value_next = ctrl.value;
        end else if (ctrl.push && is_tail && !ctrl.any_hit) begin
            key_next   = ctrl.key;
            value_next = ctrl.value;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign key   = key_reg;
    assign value = value_reg;

endmodule

// File: rtl/coalescing_key_value_fifo.sv
// Top level of the coalescing key/value FIFO: stream ports, occupancy count,
// the chain of ckvf_cell storage cells and the result register.
// Depends on ckvf_pkg and ckvf_cell.
`timescale 1ns / 1ps

// A queue of up to DEPTH key/value pairs in arrival order. A push whose key
// is already held overwrites that entry's value in place; otherwise it is
// appended, or dropped when the queue is full. A pop returns and removes the
// head entry. Every input transaction gives exactly one result transaction
// carrying a status code, the popped pair and the occupancy afterwards.
// One transaction is taken per clock cycle while s_tready is high: every cell
// compares its key with the pushed key in the same cycle and the whole chain
// shifts one place on a pop, and each command's result is registered.
// s_tready stays high while the result register is empty or being drained.
// There is no clearing pass after reset.

module coalescing_key_value_fifo
    import ckvf_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // key[15:0], value[31:16]
    input  logic                s_tuser,   // command[0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // out_key[15:0], out_value[31:16],
                                           // occupancy[36:32], is_empty[37],
                                           // is_full[38], zero[39]
    output logic [STAT_W-1:0]   m_tuser    // status[2:0]
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic               accept;
    cmd_t               cmd;
    ckvf_ctrl_t         ctrl;
    logic [DEPTH-1:0]   hits;
    logic [KEY_W-1:0]   cell_key   [DEPTH];
    logic [VALUE_W-1:0] cell_value [DEPTH];

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    status_t             status;
    logic [31:0]         count_ext;

    logic                m_valid_reg;
    logic                m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [M_DATA_W-1:0] m_data_next;
    logic [STAT_W-1:0]   m_user_reg;
    logic [STAT_W-1:0]   m_user_next;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign cmd      = cmd_t'(s_tuser);

    assign ctrl.push    = accept && (cmd == CMD_PUSH);
    assign ctrl.pop     = accept && (cmd == CMD_POP) && (count_reg != '0);
    assign ctrl.any_hit = |hits;
    assign ctrl.key     = s_tdata[KEY_W-1:0];
    assign ctrl.value   = s_tdata[KEY_W +: VALUE_W];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [KEY_W-1:0]   nb_key;
        logic [VALUE_W-1:0] nb_value;

        if (i == DEPTH - 1) begin : g_last
            // nothing behind the tail: hold own pair, it falls out of range
            assign nb_key   = cell_key[i];
            assign nb_value = cell_value[i];
        end else begin : g_mid
            assign nb_key   = cell_key[i+1];
            assign nb_value = cell_value[i+1];
        end

        ckvf_cell u_cell (
            .aclk     (aclk),
            .ctrl     (ctrl),
            .occupied (CW'(i) < count_reg),
            .is_tail  (CW'(i) == count_reg),
            .nb_key   (nb_key),
            .nb_value (nb_value),
            .key      (cell_key[i]),
            .value    (cell_value[i]),
            .hit      (hits[i])
        );
    end

    // status and next count
    always_comb begin
        count_next = count_reg;
        status     = ST_UPDATED;
        unique case (cmd)
            CMD_PUSH: begin
                priority if (ctrl.any_hit) begin
                    status = ST_UPDATED;
                end else if (count_reg == FULL_COUNT) begin
                    status = ST_DROPPED;
                end else begin
                    status     = ST_APPENDED;
                    count_next = count_reg + CW'(1);
                end
            end
            CMD_POP: begin
                if (count_reg == '0) begin
                    status = ST_EMPTY;
                end else begin
                    status     = ST_POPPED;
                    count_next = count_reg - CW'(1);
                end
            end
            default: begin
                status = ST_UPDATED;
            end
        endcase
    end

    assign count_ext = 32'(count_next);

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
            m_user_next  = status;
            m_data_next  = '0;
            if (status == ST_POPPED) begin
                m_data_next[KEY_W-1:0]         = cell_key[0];
                m_data_next[KEY_W +: VALUE_W]  = cell_value[0];
            end
            m_data_next[S_DATA_W +: OCC_W] = count_ext[OCC_W-1:0];
            m_data_next[S_DATA_W + OCC_W]     = (count_next == '0);
            m_data_next[S_DATA_W + OCC_W + 1] = (count_next == FULL_COUNT);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            m_valid_reg <= m_valid_next;
        end
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// File: bench/ckvf_checker.sv
// Checker for the coalescing key/value FIFO: mirrors the queue contents from
// accepted commands, predicts each reply and compares it with the result stream.
// Depends on ckvf_pkg.
`timescale 1ns / 1ps

module ckvf_checker
    import ckvf_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // key[15:0], value[31:16]
    input  logic                s_tuser,   // command[0]
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,   // out_key[15:0], out_value[31:16],
                                           // occupancy[36:32], is_empty[37],
                                           // is_full[38], zero[39]
    input  logic [STAT_W-1:0]   m_tuser,   // status[2:0]
    output int                  fail_count,
    output int                  replies_owed,
    output int                  replies_seen
);

    typedef struct {
        status_t            status;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [OCC_W-1:0]   occupancy;
        logic               is_empty;
        logic               is_full;
    } reply_t;

    logic [KEY_W-1:0]   held_keys   [DEPTH];
    logic [VALUE_W-1:0] held_values [DEPTH];
    int                 held_count;
    reply_t             reply_q [$];

    initial begin
        fail_count   = 0;
        replies_owed = 0;
        replies_seen = 0;
        held_count   = 0;
    end

    task automatic report(input string msg);
        // keep the log short if the block is badly broken
        if (fail_count < 50) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
        fail_count++;
    endtask

    // Apply one command to the mirrored queue and work out its reply
    task automatic coalesce_command(input cmd_t cmd, input logic [KEY_W-1:0] key,
                                    input logic [VALUE_W-1:0] value, output reply_t reply);
        bit hit;
        int i;
        hit         = 1'b0;
        reply.key   = '0;
        reply.value = '0;
        if (cmd == CMD_PUSH) begin
            // the entry nearest the head wins the search
            for (i = 0; i < held_count; i++) begin
                if (!hit && held_keys[i] == key) begin
                    held_values[i] = value;
                    hit            = 1'b1;
                end
            end
            if (hit) begin
                reply.status = ST_UPDATED;
            end else if (held_count >= DEPTH) begin
                reply.status = ST_DROPPED;
            end else begin
                held_keys[held_count]   = key;
                held_values[held_count] = value;
                held_count++;
                reply.status = ST_APPENDED;
            end
        end else if (held_count == 0) begin
            reply.status = ST_EMPTY;
        end else begin
            reply.key   = held_keys[0];
            reply.value = held_values[0];
            for (i = 0; i + 1 < held_count; i++) begin
                held_keys[i]   = held_keys[i+1];
                held_values[i] = held_values[i+1];
            end
            held_count--;
            reply.status = ST_POPPED;
        end
        reply.occupancy = OCC_W'(held_count);
        reply.is_empty  = (held_count == 0);
        reply.is_full   = (held_count >= DEPTH);
    endtask

    task automatic check_reply(input reply_t want);
        if (m_tuser != want.status)
            report($sformatf("status got %0d expected %0d", m_tuser, want.status));
        if (m_tdata[15:0] != want.key)
            report($sformatf("out_key got %h expected %h", m_tdata[15:0], want.key));
        if (m_tdata[31:16] != want.value)
            report($sformatf("out_value got %h expected %h", m_tdata[31:16], want.value));
        if (m_tdata[36:32] != want.occupancy)
            report($sformatf("occupancy got %0d expected %0d", m_tdata[36:32],
                             want.occupancy));
        if (m_tdata[37] != want.is_empty)
            report($sformatf("is_empty got %b expected %b", m_tdata[37], want.is_empty));
        if (m_tdata[38] != want.is_full)
            report($sformatf("is_full got %b expected %b", m_tdata[38], want.is_full));
    endtask

    always @(posedge aclk) begin : watch
        reply_t want;
        if (!aresetn) begin
            held_count = 0;
            reply_q.delete();
        end else begin
            // check the outgoing transaction before queueing the new command
            if (m_tvalid && m_tready) begin
                replies_seen++;
                if (reply_q.size() == 0) begin
                    report($sformatf("result with nothing outstanding: status %0d data %h",
                                     m_tuser, m_tdata));
                end else begin
                    want = reply_q.pop_front();
                    check_reply(want);
                end
            end
            if (s_tvalid && s_tready) begin
                coalesce_command(cmd_t'(s_tuser), s_tdata[15:0], s_tdata[31:16], want);
                reply_q.push_back(want);
            end
        end
        replies_owed = reply_q.size();
    end

endmodule

// File: bench/testbench.sv
// Top of the coalescing key/value FIFO testbench: clock, reset, command stimulus
// with bursts and pauses, result back-pressure, watchdog and final verdict.
// Depends on ckvf_pkg, coalescing_key_value_fifo and ckvf_checker.
`timescale 1ns / 1ps

module testbench;
    import ckvf_pkg::*;

    localparam int DEPTH          = 16;
    localparam int RANDOM_ITEMS   = 1325;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 300;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // key[15:0], value[31:16]
    logic                s_tuser  = 1'b0; // command[0]
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // out_key[15:0], out_value[31:16],
                                          // occupancy[36:32], is_empty[37],
                                          // is_full[38], zero[39]
    logic [STAT_W-1:0]   m_tuser;         // status[2:0]

    logic s_took = 1'b0;
    int   fail_count;
    int   replies_owed;
    int   replies_seen;
    int   quiet_cycles = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    coalescing_key_value_fifo #(
        .DEPTH (DEPTH)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    ckvf_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .replies_owed (replies_owed),
        .replies_seen (replies_seen)
    );

    // Handshake seen at the edge, read by the driver at the next falling edge
    always @(posedge aclk) begin
        s_took <= s_tvalid && s_tready;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Offer one command and hold it until the transaction completes
    task automatic offer(input cmd_t cmd, input logic [KEY_W-1:0] key,
                         input logic [VALUE_W-1:0] value);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {value, key};
        do @(negedge aclk); while (!s_took);
    endtask

    task automatic idle(input int cycles);
        s_tvalid <= 1'b0;
        s_tdata  <= S_DATA_W'($urandom);
        s_tuser  <= 1'($urandom);
        repeat (cycles) @(negedge aclk);
    endtask

    // Hold off until every outstanding result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (replies_owed != 0);
    endtask

    // Receiver: changing stall patterns, plus one long hold-off
    initial begin : receiver
        bit held_off;
        int mode;
        int phase;
        held_off = 1'b0;
        mode     = 0;
        phase    = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!held_off && replies_seen >= 400) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end
            if (phase == 0) begin
                mode  = $urandom_range(0, 3);
                phase = $urandom_range(16, 96);
            end
            phase--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 99) < 75);
                2: m_tready <= ($urandom_range(0, 99) < 25);
                default: m_tready <= ~m_tready;
            endcase
        end
    end

    initial begin : stimulus
        logic [KEY_W-1:0] key_pool [24];
        logic [KEY_W-1:0] key;
        int               burst_left;
        int               push_pct;
        int               gap;
        int               n;
        cmd_t             cmd;

        burst_left = 0;
        push_pct   = 50;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty pop, key extremes, in-place update, drain to empty
        offer(CMD_POP,  16'hFFFF, 16'hFFFF);
        offer(CMD_PUSH, 16'h0000, 16'h0000);
        offer(CMD_PUSH, 16'hFFFF, 16'hFFFF);
        offer(CMD_PUSH, 16'h0000, 16'hFFFF);
        offer(CMD_PUSH, 16'hFFFF, 16'h1234);
        offer(CMD_POP,  16'h0000, 16'h0000);
        offer(CMD_POP,  16'h5A5A, 16'hA5A5);
        offer(CMD_POP,  16'h0000, 16'h0000);
        // Fill to the brim, then a new key is dropped and a held key still updates
        for (n = 0; n < DEPTH; n++) begin
            offer(CMD_PUSH, KEY_W'(n * 16'h1111), VALUE_W'(~(n * 16'h1111)));
        end
        offer(CMD_PUSH, 16'h1234, 16'hBEEF);
        offer(CMD_PUSH, 16'hFFFF, 16'h0F0F);
        drain();

        // Random: segments of differing push/pop balance over a small key pool
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 3))
                    0: push_pct = 25;
                    1: push_pct = 50;
                    2: push_pct = 65;
                    default: push_pct = 90;
                endcase
                foreach (key_pool[i]) key_pool[i] = KEY_W'($urandom);
            end
            if (n == 650)
                drain();
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                    idle(gap);
                burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
            key = ($urandom_range(0, 4) == 0) ? KEY_W'($urandom)
                                              : key_pool[$urandom_range(0, 23)];
            offer(cmd, key, VALUE_W'($urandom));
        end

        drain();
        repeat (10) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
